// File: hw/rtl/fifo_with_read_commit_revert_defines.svh
// assertion macros for the fifo rtl
// no dependencies; included by modules that carry assertions
`ifndef FIFO_WITH_READ_COMMIT_REVERT_DEFINES_SVH
`define FIFO_WITH_READ_COMMIT_REVERT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// check a property on the rising clock, masked while reset is low
`define FWCR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check a property on the rising clock, also during reset
`define FWCR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FWCR_ASSERT(lbl, clk, rst_n, prop, msg)
`define FWCR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: hw/rtl/fwcr_pkg.sv
// types, constants and helpers for the fifo with read commit and revert
// no dependencies
`timescale 1ns / 1ps

package fwcr_pkg;

    // store geometry, fixed by the port widths
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int SLOT_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CFG_W      = 5;
    localparam int CFG_IDX_W  = 4;
    localparam int OP_W       = 3;
    localparam int SUM_W      = ((SLOT_W > CFG_W) ? SLOT_W : CFG_W) + 1;

    // opcodes
    localparam logic [OP_W-1:0] OP_STATUS = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH   = 3'd1;
    localparam logic [OP_W-1:0] OP_POP    = 3'd2;
    localparam logic [OP_W-1:0] OP_COMMIT = 3'd3;
    localparam logic [OP_W-1:0] OP_REVERT = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NEARLY_EMPTY_LEVEL = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEARLY_FULL_MARGIN = 4'd1;

    // store write request
    typedef struct packed {
        logic                  en;
        logic [SLOT_W-1:0]     slot;
        logic [DATA_WIDTH-1:0] data;
    } t_store_wr;

    // one result
    typedef struct packed {
        logic [DATA_WIDTH-1:0] read_data;
        logic                  accepted;
        logic [SLOT_W-1:0]     slot_index;
        logic                  is_empty;
        logic                  is_full;
        logic                  is_nearly_empty;
        logic                  is_nearly_full;
        logic                  underflow_seen;
        logic                  overflow_seen;
        logic [CNT_W-1:0]      entry_count;
        logic [CNT_W-1:0]      space_count;
    } t_result;

    // next slot with wrap
    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] p);
        logic [SLOT_W-1:0] q;
        q = (p == SLOT_W'(DEPTH - 1)) ? '0 : p + 1'b1;
        return q;
    endfunction

    // distance from tail to head around the ring
    function automatic logic [SLOT_W-1:0] occupancy(input logic [SLOT_W-1:0] head,
                                                    input logic [SLOT_W-1:0] tail);
        logic [SLOT_W:0] d;
        d = {1'b0, head} - {1'b0, tail};
        if (head < tail) begin
            d = d + (SLOT_W + 1)'(DEPTH);
        end
        return d[SLOT_W-1:0];
    endfunction

endpackage

// File: hw/rtl/fwcr_store.sv
// entry store of the fifo, one write and one read slot per cycle
// depends on fwcr_pkg
`timescale 1ns / 1ps

module fwcr_store (
    input  logic                           i_clk,
    input  fwcr_pkg::t_store_wr            i_wr,
    input  logic [fwcr_pkg::SLOT_W-1:0]    i_rd_slot,
    output logic [fwcr_pkg::DATA_WIDTH-1:0] o_rd_data
);
    import fwcr_pkg::*;

    logic [DATA_WIDTH-1:0] r_entry [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_entry[i_wr.slot] <= i_wr.data;
        end
    end

    // registered read at the upcoming read slot, a write to that slot passes through
    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.slot == i_rd_slot)) begin
            r_rd_data <= i_wr.data;
        end else begin
            r_rd_data <= r_entry[i_rd_slot];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/fwcr_ctrl.sv
// pointer, flag and sticky state of the fifo plus the per-request result
// depends on fwcr_pkg and fifo_with_read_commit_revert_defines.svh
`timescale 1ns / 1ps

`include "fifo_with_read_commit_revert_defines.svh"

module fwcr_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_fire,
    input  logic [fwcr_pkg::OP_W-1:0]       i_opcode,
    input  logic [fwcr_pkg::DATA_WIDTH-1:0] i_write_data,
    input  logic [fwcr_pkg::CFG_W-1:0]      i_nearly_empty_level,
    input  logic [fwcr_pkg::CFG_W-1:0]      i_nearly_full_margin,
    input  logic [fwcr_pkg::DATA_WIDTH-1:0] i_rd_data,
    output logic [fwcr_pkg::SLOT_W-1:0]     o_rd_slot,
    output fwcr_pkg::t_store_wr             o_wr,
    output fwcr_pkg::t_result               o_result
);
    import fwcr_pkg::*;

    logic [SLOT_W-1:0] r_read_slot, n_read_slot;
    logic [SLOT_W-1:0] r_commit_slot, n_commit_slot;
    logic [SLOT_W-1:0] r_write_slot, n_write_slot;
    logic r_full, n_full;
    logic r_empty, n_empty;
    logic r_nfull, n_nfull;
    logic r_nempty, n_nempty;
    logic r_underflow, n_underflow;
    logic r_overflow, n_overflow;

    logic                  upd;
    logic                  hint;
    logic                  ok;
    logic [SLOT_W-1:0]     slot;
    logic [DATA_WIDTH-1:0] rdata;
    logic [SLOT_W-1:0]     occ_c;
    logic [SLOT_W-1:0]     occ_u;
    logic                  f_full;
    logic                  f_nfull;
    logic                  f_empty;
    logic                  f_nempty;
    logic [CNT_W-1:0]      count;

    // opcode decode and pointer moves
    always_comb begin
        n_read_slot   = r_read_slot;
        n_commit_slot = r_commit_slot;
        n_write_slot  = r_write_slot;
        n_underflow   = r_underflow;
        n_overflow    = r_overflow;
        upd           = 1'b0;
        hint          = 1'b0;
        ok            = 1'b1;
        slot          = '0;
        rdata         = '0;
        o_wr.en       = 1'b0;
        o_wr.slot     = r_write_slot;
        o_wr.data     = i_write_data;
        unique case (i_opcode)
            OP_PUSH: begin
                if (r_full) begin
                    n_overflow = 1'b1;
                    ok         = 1'b0;
                end else begin
                    slot         = r_write_slot;
                    o_wr.en      = i_fire;
                    n_write_slot = slot_inc(r_write_slot);
                    upd          = 1'b1;
                    hint         = 1'b1;
                end
            end
            OP_POP: begin
                if (r_empty) begin
                    n_underflow = 1'b1;
                    ok          = 1'b0;
                end else begin
                    slot        = r_read_slot;
                    rdata       = i_rd_data;
                    n_read_slot = slot_inc(r_read_slot);
                    upd         = 1'b1;
                    hint        = r_full;
                end
            end
            OP_COMMIT: begin
                if (r_commit_slot != r_read_slot) begin
                    n_commit_slot = r_read_slot;
                    upd           = 1'b1;
                end
            end
            OP_REVERT: begin
                n_read_slot = r_commit_slot;
                upd         = 1'b1;
                hint        = r_full;
            end
            OP_CLEAR: begin
                n_read_slot   = '0;
                n_commit_slot = '0;
                n_write_slot  = '0;
                n_underflow   = 1'b0;
                n_overflow    = 1'b0;
                upd           = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // flag recompute from the new pointers
    always_comb begin
        occ_c = occupancy(n_write_slot, n_commit_slot);
        occ_u = occupancy(n_write_slot, n_read_slot);
        if (occ_c == '0) begin
            f_full  = hint;
            f_nfull = hint;
        end else begin
            f_full  = 1'b0;
            f_nfull = (SUM_W'(occ_c) + SUM_W'(i_nearly_full_margin)) >= SUM_W'(DEPTH);
        end
        if (occ_u == '0) begin
            f_empty  = !f_full;
            f_nempty = !f_full;
        end else begin
            f_empty  = 1'b0;
            f_nempty = SUM_W'(occ_u) <= SUM_W'(i_nearly_empty_level);
        end
        n_full   = upd ? f_full   : r_full;
        n_nfull  = upd ? f_nfull  : r_nfull;
        n_empty  = upd ? f_empty  : r_empty;
        n_nempty = upd ? f_nempty : r_nempty;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_slot   <= '0;
            r_commit_slot <= '0;
            r_write_slot  <= '0;
            r_full        <= 1'b0;
            r_empty       <= 1'b1;
            r_nfull       <= 1'b0;
            r_nempty      <= 1'b1;
            r_underflow   <= 1'b0;
            r_overflow    <= 1'b0;
        end else if (i_fire) begin
            r_read_slot   <= n_read_slot;
            r_commit_slot <= n_commit_slot;
            r_write_slot  <= n_write_slot;
            r_full        <= n_full;
            r_empty       <= n_empty;
            r_nfull       <= n_nfull;
            r_nempty      <= n_nempty;
            r_underflow   <= n_underflow;
            r_overflow    <= n_overflow;
        end
    end

    // result for this request
    always_comb begin
        count                    = n_full ? CNT_W'(DEPTH) : CNT_W'(occ_c);
        o_result.read_data       = rdata;
        o_result.accepted        = ok;
        o_result.slot_index      = slot;
        o_result.is_empty        = n_empty;
        o_result.is_full         = n_full;
        o_result.is_nearly_empty = n_nempty;
        o_result.is_nearly_full  = n_nfull;
        o_result.underflow_seen  = n_underflow;
        o_result.overflow_seen   = n_overflow;
        o_result.entry_count     = count;
        o_result.space_count     = CNT_W'(DEPTH) - count;
    end

    // store read address: the read slot as it will stand after this edge
    assign o_rd_slot = !i_rst_n ? '0 : (i_fire ? n_read_slot : r_read_slot);

    `FWCR_ASSERT(a_full_empty_excl, i_clk, i_rst_n, !(r_full && r_empty),
                 "full and empty both set")
    `FWCR_ASSERT(a_full_ptrs, i_clk, i_rst_n, r_full |-> (r_write_slot == r_commit_slot),
                 "full with committed entries outstanding")
    `FWCR_ASSERT(a_overflow_set, i_clk, i_rst_n,
                 (i_fire && i_opcode == OP_PUSH && r_full) |=> r_overflow,
                 "push while full did not set overflow")
    `FWCR_ASSERT(a_underflow_set, i_clk, i_rst_n,
                 (i_fire && i_opcode == OP_POP && r_empty) |=> r_underflow,
                 "pop while empty did not set underflow")

endmodule

// File: hw/rtl/fifo_with_read_commit_revert.sv
// Fifo with speculative reads, commit and revert, driven by one request at a time.
// Each request's result is computed combinationally and captured in the output register when the request is taken.
// Throughput: one request per cycle while the input is not stalled; pointer and flag logic is combinational.
// Input stalls only while a finished result waits under an output stall.
// Synchronous active-low reset clears pointers, full flags and stickies, sets the empty
// flags, and sets both registers to 2; entry data is left undefined until written.
`timescale 1ns / 1ps

module fifo_with_read_commit_revert (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [fwcr_pkg::OP_W-1:0]        i_opcode,
    input  logic [fwcr_pkg::DATA_WIDTH-1:0]  i_write_data,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [fwcr_pkg::DATA_WIDTH-1:0]  o_read_data,
    output logic                             o_accepted,
    output logic [fwcr_pkg::SLOT_W-1:0]      o_slot_index,
    output logic                             o_is_empty,
    output logic                             o_is_full,
    output logic                             o_is_nearly_empty,
    output logic                             o_is_nearly_full,
    output logic                             o_underflow_seen,
    output logic                             o_overflow_seen,
    output logic [fwcr_pkg::CNT_W-1:0]       o_entry_count,
    output logic [fwcr_pkg::CNT_W-1:0]       o_space_count,
    // register write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [fwcr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fwcr_pkg::CFG_W-1:0]       i_cfg_data
);
    import fwcr_pkg::*;

    logic [CFG_W-1:0]      r_ne_level;
    logic [CFG_W-1:0]      r_nf_margin;
    logic                  r_out_valid;
    t_result               r_out;
    t_result               result;
    t_store_wr             wr;
    logic [SLOT_W-1:0]     rd_slot;
    logic [DATA_WIDTH-1:0] rd_data;
    logic                  fire;

    // handshake
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign fire        = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ne_level  <= CFG_W'(2);
            r_nf_margin <= CFG_W'(2);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_NEARLY_EMPTY_LEVEL: r_ne_level  <= i_cfg_data;
                REG_NEARLY_FULL_MARGIN: r_nf_margin <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    fwcr_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_slot (rd_slot),
        .o_rd_data (rd_data)
    );

    fwcr_ctrl u_ctrl (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_fire               (fire),
        .i_opcode             (i_opcode),
        .i_write_data         (i_write_data),
        .i_nearly_empty_level (r_ne_level),
        .i_nearly_full_margin (r_nf_margin),
        .i_rd_data            (rd_data),
        .o_rd_slot            (rd_slot),
        .o_wr                 (wr),
        .o_result             (result)
    );

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_read_data       = r_out.read_data;
    assign o_accepted        = r_out.accepted;
    assign o_slot_index      = r_out.slot_index;
    assign o_is_empty        = r_out.is_empty;
    assign o_is_full         = r_out.is_full;
    assign o_is_nearly_empty = r_out.is_nearly_empty;
    assign o_is_nearly_full  = r_out.is_nearly_full;
    assign o_underflow_seen  = r_out.underflow_seen;
    assign o_overflow_seen   = r_out.overflow_seen;
    assign o_entry_count     = r_out.entry_count;
    assign o_space_count     = r_out.space_count;

endmodule

// File: test/fifo_with_read_commit_revert_tb.sv
// self-checking testbench for the fifo with read commit and revert
// depends on fwcr_pkg and the fifo_with_read_commit_revert rtl only
`timescale 1ns / 1ps

module fifo_with_read_commit_revert_tb;
    import fwcr_pkg::*;

    // spare opcodes behave as status; spare register index is ignored
    localparam logic [OP_W-1:0]      OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0]      OP_SPARE_7 = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 8;
    localparam int OPS_PER_PHASE  = 99;
    localparam int N_ROWS         = 24;

    // results that can be read straight off the spec
    localparam t_result NO_CHECK = '0;
    localparam t_result IDLE_EMPTY = '{read_data: '0, accepted: 1'b1, slot_index: '0,
        is_empty: 1'b1, is_full: 1'b0, is_nearly_empty: 1'b1, is_nearly_full: 1'b0,
        underflow_seen: 1'b0, overflow_seen: 1'b0, entry_count: 5'd0, space_count: 5'd16};
    localparam t_result UNDERFLOW_EMPTY = '{read_data: '0, accepted: 1'b0, slot_index: '0,
        is_empty: 1'b1, is_full: 1'b0, is_nearly_empty: 1'b1, is_nearly_full: 1'b0,
        underflow_seen: 1'b1, overflow_seen: 1'b0, entry_count: 5'd0, space_count: 5'd16};
    localparam t_result OVERFLOW_FULL = '{read_data: '0, accepted: 1'b0, slot_index: '0,
        is_empty: 1'b0, is_full: 1'b1, is_nearly_empty: 1'b0, is_nearly_full: 1'b1,
        underflow_seen: 1'b0, overflow_seen: 1'b1, entry_count: 5'd16, space_count: 5'd0};

    typedef struct {
        logic [OP_W-1:0]       op;
        logic [DATA_WIDTH-1:0] data;
        int                    reps;
        bit                    typed;
        t_result               want;
    } t_op_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [OP_W-1:0]        i_opcode;
    logic [DATA_WIDTH-1:0]  i_write_data;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [DATA_WIDTH-1:0]  o_read_data;
    logic                   o_accepted;
    logic [SLOT_W-1:0]      o_slot_index;
    logic                   o_is_empty;
    logic                   o_is_full;
    logic                   o_is_nearly_empty;
    logic                   o_is_nearly_full;
    logic                   o_underflow_seen;
    logic                   o_overflow_seen;
    logic [CNT_W-1:0]       o_entry_count;
    logic [CNT_W-1:0]       o_space_count;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_W-1:0]       i_cfg_data;

    fifo_with_read_commit_revert dut (.*);

    // shadow fifo state
    logic [DATA_WIDTH-1:0] shadow_store [DEPTH];
    logic [SLOT_W-1:0]     rd_slot, cm_slot, wr_slot;
    logic                  sh_full, sh_empty, sh_nfull, sh_nempty;
    logic                  sh_underflow, sh_overflow;
    logic [CFG_W-1:0]      ne_level, nf_margin;

    t_result status_due [$];
    t_op_row op_table [N_ROWS];
    int      burst_left;
    int      idle_cycles;
    int      mismatches;
    int      requests_sent;
    int      results_checked;
    int      settings_used;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // recompute the four level flags, hint resolves equal pointers
    task automatic refresh_flags(input logic hint);
        logic [SLOT_W-1:0] occ_c, occ_u;
        occ_c = wr_slot - cm_slot;
        occ_u = wr_slot - rd_slot;
        if (occ_c == '0) begin
            sh_full  = hint;
            sh_nfull = hint;
        end else begin
            sh_full  = 1'b0;
            sh_nfull = (int'(occ_c) + int'(nf_margin)) >= DEPTH;
        end
        if (occ_u == '0) begin
            sh_empty  = ~sh_full;
            sh_nempty = ~sh_full;
        end else begin
            sh_empty  = 1'b0;
            sh_nempty = {1'b0, occ_u} <= ne_level;
        end
    endtask

    // apply one request to the shadow fifo and form its status
    task automatic fifo_step(input logic [OP_W-1:0] op, input logic [DATA_WIDTH-1:0] wd,
                             output t_result r);
        logic [CNT_W-1:0]  count;
        logic [SLOT_W-1:0] occ;
        r = '0;
        r.accepted = 1'b1;
        case (op)
            OP_PUSH: begin
                if (sh_full) begin
                    sh_overflow = 1'b1;
                    r.accepted = 1'b0;
                end else begin
                    r.slot_index = wr_slot;
                    shadow_store[wr_slot] = wd;
                    wr_slot = wr_slot + 1'b1;
                    refresh_flags(1'b1);
                end
            end
            OP_POP: begin
                if (sh_empty) begin
                    sh_underflow = 1'b1;
                    r.accepted = 1'b0;
                end else begin
                    r.slot_index = rd_slot;
                    r.read_data = shadow_store[rd_slot];
                    rd_slot = rd_slot + 1'b1;
                    refresh_flags(sh_full);
                end
            end
            OP_COMMIT: begin
                if (cm_slot != rd_slot) begin
                    cm_slot = rd_slot;
                    refresh_flags(1'b0);
                end
            end
            OP_REVERT: begin
                rd_slot = cm_slot;
                refresh_flags(sh_full);
            end
            OP_CLEAR: begin
                rd_slot = '0;
                cm_slot = '0;
                wr_slot = '0;
                sh_underflow = 1'b0;
                sh_overflow = 1'b0;
                refresh_flags(1'b0);
            end
            default: ;
        endcase
        occ = wr_slot - cm_slot;
        count = sh_full ? CNT_W'(DEPTH) : {1'b0, occ};
        r.is_empty        = sh_empty;
        r.is_full         = sh_full;
        r.is_nearly_empty = sh_nempty;
        r.is_nearly_full  = sh_nfull;
        r.underflow_seen  = sh_underflow;
        r.overflow_seen   = sh_overflow;
        r.entry_count     = count;
        r.space_count     = CNT_W'(DEPTH) - count;
    endtask

    // send one request in bursts with random gaps; entered and left at a falling edge
    task automatic send_op(input logic [OP_W-1:0] op, input logic [DATA_WIDTH-1:0] data,
                           input bit typed, input t_result want);
        t_result next_status;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid   = 1'b1;
        i_opcode     = op;
        i_write_data = data;
        do @(posedge i_clk); while (o_in_stall);
        fifo_step(op, data, next_status);
        status_due.push_back(typed ? want : next_status);
        requests_sent++;
        @(negedge i_clk);
    endtask

    // drain all results, then let the pipeline settle
    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (status_due.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // one register write; entered and left at a falling edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_NEARLY_EMPTY_LEVEL) begin
            ne_level = val;
        end else if (idx == REG_NEARLY_FULL_MARGIN) begin
            nf_margin = val;
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [DATA_WIDTH-1:0] exp_v,
                               input logic [DATA_WIDTH-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // compare each delivered status with the oldest one due
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (status_due.size() == 0) begin
                $error("result delivered with no request outstanding");
                mismatches++;
            end else begin
                want = status_due.pop_front();
                check_field("read_data", want.read_data, o_read_data);
                check_field("accepted", DATA_WIDTH'(want.accepted),
                            DATA_WIDTH'(o_accepted));
                check_field("slot_index", DATA_WIDTH'(want.slot_index),
                            DATA_WIDTH'(o_slot_index));
                check_field("is_empty", DATA_WIDTH'(want.is_empty),
                            DATA_WIDTH'(o_is_empty));
                check_field("is_full", DATA_WIDTH'(want.is_full),
                            DATA_WIDTH'(o_is_full));
                check_field("is_nearly_empty", DATA_WIDTH'(want.is_nearly_empty),
                            DATA_WIDTH'(o_is_nearly_empty));
                check_field("is_nearly_full", DATA_WIDTH'(want.is_nearly_full),
                            DATA_WIDTH'(o_is_nearly_full));
                check_field("underflow_seen", DATA_WIDTH'(want.underflow_seen),
                            DATA_WIDTH'(o_underflow_seen));
                check_field("overflow_seen", DATA_WIDTH'(want.overflow_seen),
                            DATA_WIDTH'(o_overflow_seen));
                check_field("entry_count", DATA_WIDTH'(want.entry_count),
                            DATA_WIDTH'(o_entry_count));
                check_field("space_count", DATA_WIDTH'(want.space_count),
                            DATA_WIDTH'(o_space_count));
                results_checked++;
            end
        end
    end

    // watchdog on cycles where no channel moves anything
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side stall pattern: quiet stretches, light and heavy stalling
    initial begin : out_stall_pattern
        int mode;
        int span;
        i_out_stall = 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(10, 60);
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    0:       i_out_stall = 1'b0;
                    1:       i_out_stall = ($urandom_range(0, 2) == 0);
                    default: i_out_stall = ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // main sequence
    initial begin : run
        int k;
        int r;
        int push_pct;
        logic [OP_W-1:0]       op;
        logic [DATA_WIDTH-1:0] data;
        logic [CFG_W-1:0]      lvl, mrg;

        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_opcode     = OP_STATUS;
        i_write_data = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = REG_NEARLY_EMPTY_LEVEL;
        i_cfg_data   = '0;
        idle_cycles  = 0;
        burst_left   = 0;
        mismatches   = 0;
        requests_sent = 0;
        results_checked = 0;
        settings_used = 1;

        // shadow state at reset
        for (k = 0; k < DEPTH; k++) shadow_store[k] = '0;
        rd_slot = '0;
        cm_slot = '0;
        wr_slot = '0;
        sh_full = 1'b0;
        sh_empty = 1'b1;
        sh_nfull = 1'b0;
        sh_nempty = 1'b1;
        sh_underflow = 1'b0;
        sh_overflow = 1'b0;
        ne_level = 5'd2;
        nf_margin = 5'd2;

        // directed rows: op, data, repeat count, typed flag, typed result
        op_table = '{
            '{OP_STATUS,  32'h0000_0000, 1,  1'b1, IDLE_EMPTY},
            '{OP_POP,     32'h0000_0000, 1,  1'b1, UNDERFLOW_EMPTY},
            '{OP_PUSH,    32'h0000_0000, 1,  1'b0, NO_CHECK},
            '{OP_PUSH,    32'hffff_ffff, 1,  1'b0, NO_CHECK},
            '{OP_PUSH,    32'ha5a5_a5a5, 1,  1'b0, NO_CHECK},
            '{OP_PUSH,    32'h5a5a_5a5a, 1,  1'b0, NO_CHECK},
            '{OP_POP,     32'h0000_0000, 1,  1'b0, NO_CHECK},
            '{OP_POP,     32'h0000_0000, 1,  1'b0, NO_CHECK},
            '{OP_REVERT,  32'h0000_0000, 1,  1'b0, NO_CHECK},
            '{OP_POP,     32'h0000_0000, 3,  1'b0, NO_CHECK},
            '{OP_COMMIT,  32'h0000_0000, 1,  1'b0, NO_CHECK},
            '{OP_COMMIT,  32'hffff_ffff, 1,  1'b0, NO_CHECK},
            '{OP_SPARE_6, 32'h1234_5678, 1,  1'b0, NO_CHECK},
            '{OP_SPARE_7, 32'h8765_4321, 1,  1'b0, NO_CHECK},
            '{OP_POP,     32'h0000_0000, 1,  1'b0, NO_CHECK},
            '{OP_POP,     32'h0000_0000, 1,  1'b0, NO_CHECK},
            '{OP_CLEAR,   32'h0000_0000, 1,  1'b1, IDLE_EMPTY},
            '{OP_PUSH,    32'h8000_0000, 16, 1'b0, NO_CHECK},
            '{OP_PUSH,    32'h1234_5678, 1,  1'b1, OVERFLOW_FULL},
            '{OP_POP,     32'h0000_0000, 16, 1'b0, NO_CHECK},
            '{OP_POP,     32'h0000_0000, 2,  1'b0, NO_CHECK},
            '{OP_COMMIT,  32'h0000_0000, 1,  1'b0, NO_CHECK},
            '{OP_REVERT,  32'h0000_0000, 1,  1'b0, NO_CHECK},
            '{OP_CLEAR,   32'h0000_0000, 1,  1'b1, IDLE_EMPTY}
        };

        // reset held from time zero, released at a falling edge
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part at the reset register values
        foreach (op_table[row]) begin
            for (k = 0; k < op_table[row].reps; k++) begin
                send_op(op_table[row].op, op_table[row].data + DATA_WIDTH'(k),
                        op_table[row].typed, op_table[row].want);
            end
        end

        // random phases, each under its own register setting
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       begin lvl = 5'd0;  mrg = 5'd0;  end
                1:       begin lvl = 5'd16; mrg = 5'd16; end
                2:       begin lvl = 5'd31; mrg = 5'd31; end
                3:       begin lvl = 5'd1;  mrg = 5'd15; end
                4:       begin lvl = 5'd15; mrg = 5'd1;  end
                default: begin
                    lvl = CFG_W'($urandom_range(0, 31));
                    mrg = CFG_W'($urandom_range(0, 31));
                end
            endcase
            wait_idle();
            write_reg(REG_NEARLY_EMPTY_LEVEL, lvl);
            write_reg(REG_NEARLY_FULL_MARGIN, mrg);
            if (phase == 3) begin
                write_reg(REG_UNUSED, 5'h1f);
            end
            settings_used++;
            push_pct = 50;
            for (int n = 0; n < OPS_PER_PHASE; n++) begin
                // alternate fill-heavy, drain-heavy and balanced stretches
                if (n % 25 == 0) begin
                    case ($urandom_range(0, 2))
                        0:       push_pct = 85;
                        1:       push_pct = 15;
                        default: push_pct = 50;
                    endcase
                end
                r = $urandom_range(0, 99);
                if (r < 2) begin
                    op = OP_CLEAR;
                end else if (r < 3) begin
                    op = OP_STATUS;
                end else if (r < 4) begin
                    op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
                end else if (r < 11) begin
                    op = OP_COMMIT;
                end else if (r < 15) begin
                    op = OP_REVERT;
                end else begin
                    op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
                end
                case ($urandom_range(0, 15))
                    0:       data = '0;
                    1:       data = '1;
                    default: data = $urandom();
                endcase
                send_op(op, data, 1'b0, NO_CHECK);
            end
        end

        // drain and let the block settle
        wait_idle();
        repeat (4) @(negedge i_clk);

        $display("ran %0d requests, %0d results checked, %0d register settings",
                 requests_sent, results_checked, settings_used);
        $display("directed rows covered empty, full, wrap, commit, revert and clear cases");
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/fwcr_pkg.sv
hw/rtl/fwcr_store.sv
hw/rtl/fwcr_ctrl.sv
hw/rtl/fifo_with_read_commit_revert.sv
test/fifo_with_read_commit_revert_tb.sv
